@@ rtl/core/rv32im_integer_execute_macros.svh @@
// Assertion macros for the integer execute block and its checker.
// Depends on nothing; included by the checker file.
`ifndef RV32IM_INTEGER_EXECUTE_MACROS_SVH
`define RV32IM_INTEGER_EXECUTE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RV32IE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rv32ie assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RV32IE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rv32ie assertion failed");

`endif

@@ rtl/core/rv32ie_pkg.sv @@
// Package for the integer execute block: item types, opcodes, function codes,
// controller states and default sizes. No dependencies.
`default_nettype none
package rv32ie_pkg;

    localparam int DMEM_WORDS_DEF = 4096;
    localparam int PC_BITS_DEF    = 16;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [7:0]  in_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        in_used;
        logic        illegal;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DIV,
        S_DIVWB
    } t_state;

    localparam logic [6:0] OPC_CUSTOM = 7'b0001011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;

    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_DIV  = 3'd4;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;

    localparam logic [2:0] F3_JALR = 3'd0;

endpackage
`default_nettype wire

@@ rtl/core/rv32ie_div.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle, RISC-V rules
// for divide by zero and overflow. Depends on nothing but its ports.
`default_nettype none
module rv32ie_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_mb;
    logic        r_neg;
    logic        r_zero;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem, r_quo[31]};
    assign fits   = rem_sh >= {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_mb   <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg  <= i_dividend[31] ^ i_divisor[31];
            r_zero <= (i_divisor == 32'd0);
        end else if (r_busy) begin
            r_rem <= fits ? 32'(rem_sh - {1'b0, r_mb}) : rem_sh[31:0];
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_zero ? 32'hFFFF_FFFF : (r_neg ? (32'd0 - r_quo) : r_quo);
endmodule
`default_nettype wire

@@ rtl/core/rv32im_integer_execute.sv @@
// Executes one RV32IM-subset instruction per item against a register-file
// memory (two read ports, one write port) and a data memory (one read, one
// write port), both with registered reads. After reset a clearing pass writes
// zero to every data memory word with the input stalled. An item then passes
// through accept with register read, then execute and commit; a load adds a
// data memory read, and a divide adds the 32 steps of the iterative divider
// plus start and write back.
// Commit waits while the output register holds an item that is stalled.
// Depends on rv32ie_pkg and rv32ie_div.
`default_nettype none
module rv32im_integer_execute #(
    parameter int DMEM_WORDS = rv32ie_pkg::DMEM_WORDS_DEF,
    parameter int PC_BITS    = rv32ie_pkg::PC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire rv32ie_pkg::t_in_item i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rv32ie_pkg::t_out_item     o_out_data
);
    import rv32ie_pkg::*;

    localparam int DM_AW = $clog2(DMEM_WORDS);

    t_state r_state, n_state;

    logic [31:0] r_rf [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_rd_a, r_rd_b;
    logic        r_va, r_vb;

    logic [31:0] r_dm [DMEM_WORDS];
    logic [31:0] r_dm_q;
    logic [DM_AW-1:0] r_clr;
    logic        r_ld_ok;

    logic [31:0]        r_ir;
    logic [7:0]         r_ib;
    logic [PC_BITS-1:0] r_pc;

    logic      r_out_valid;
    t_out_item r_out;

    logic       in_acc, out_free, commit, clr_last;
    logic [4:0] b_sel;

    // decoded fields
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, immi, imms, immb, immj, pc32, npc32, sum_i, sum_s;
    logic [29:0] ld_idx, st_idx;

    // execute results
    logic        ex_wb_en, ex_ill, ex_ov, ex_iu, ex_load, ex_div, ex_st, ex_ld_ok;
    logic [31:0] ex_wb, ex_st_val;
    logic [7:0]  ex_ob;
    logic [31:0] ld_m, ld_val;
    logic        wb_en;
    logic [31:0] wb_val;
    logic        div_done;
    logic [31:0] div_q;
    logic              dm_we;
    logic [DM_AW-1:0]  dm_wa;
    logic [31:0]       dm_wd;

    function automatic logic [31:0] off_words(input logic [31:0] off);
        logic [31:0] q;
        q = (32'd0 - off) >> 2;
        return off[31] ? (32'd0 - q) : (off >> 2);
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign clr_last = (r_clr == DM_AW'(DMEM_WORDS - 1));
    // the custom input instruction reads rd instead of rs2
    assign b_sel    = (i_in_data.instr_word[6:0] == OPC_CUSTOM) ?
                      i_in_data.instr_word[11:7] : i_in_data.instr_word[24:20];

    // register file: registered reads, entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_a <= r_rf[i_in_data.instr_word[19:15]];
            r_rd_b <= r_rf[b_sel];
            r_va   <= r_rf_vld[i_in_data.instr_word[19:15]];
            r_vb   <= r_rf_vld[b_sel];
            r_ir   <= i_in_data.instr_word;
            r_ib   <= i_in_data.in_byte;
        end
        if (wb_en) begin
            r_rf[rd] <= wb_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (wb_en) begin
            r_rf_vld[rd] <= 1'b1;
        end
    end

    // data memory
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dm[dm_wa] <= dm_wd;
        end
        r_dm_q <= r_dm[ld_idx[DM_AW-1:0]];
        if (r_state == S_EXEC) begin
            r_ld_ok <= ex_ld_ok;
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            dm_we = 1'b1;
            dm_wa = r_clr;
            dm_wd = '0;
        end else begin
            dm_we = commit && (r_state == S_EXEC) && ex_st;
            dm_wa = st_idx[DM_AW-1:0];
            dm_wd = ex_st_val;
        end
    end

    // decode and execute
    assign op    = r_ir[6:0];
    assign f3    = r_ir[14:12];
    assign f7    = r_ir[31:25];
    assign rd    = r_ir[11:7];
    assign a     = r_va ? r_rd_a : 32'd0;
    assign b     = r_vb ? r_rd_b : 32'd0;
    assign immi  = {{20{r_ir[31]}}, r_ir[31:20]};
    assign imms  = {{20{r_ir[31]}}, r_ir[31:25], r_ir[11:7]};
    assign immb  = {{19{r_ir[31]}}, r_ir[31], r_ir[7], r_ir[30:25], r_ir[11:8], 1'b0};
    assign immj  = {{11{r_ir[31]}}, r_ir[31], r_ir[19:12], r_ir[20], r_ir[30:21], 1'b0};
    assign pc32  = 32'(r_pc);
    assign sum_i = a + immi;
    assign sum_s = a + imms;
    assign ld_idx = sum_i[31:2];
    assign st_idx = sum_s[31:2];
    assign ex_ld_ok = ld_idx < 30'(DMEM_WORDS);

    always_comb begin
        ex_wb_en  = 1'b0;
        ex_wb     = '0;
        ex_ill    = 1'b0;
        ex_ov     = 1'b0;
        ex_ob     = '0;
        ex_iu     = 1'b0;
        ex_load   = 1'b0;
        ex_div    = 1'b0;
        ex_st     = 1'b0;
        ex_st_val = b;
        npc32     = pc32 + 32'd1;
        priority if (op == OPC_CUSTOM) begin
            if (!r_ir[12]) begin
                ex_wb_en = 1'b1;
                ex_wb    = {b[31:8], r_ib};
                ex_iu    = 1'b1;
            end else begin
                ex_ov = 1'b1;
                ex_ob = a[7:0];
            end
        end else if (op == OPC_LUI) begin
            ex_wb_en = 1'b1;
            ex_wb    = {r_ir[31:12], 12'd0};
        end else if (op == OPC_AUIPC) begin
            ex_wb_en = 1'b1;
            ex_wb    = {r_ir[31:12], 12'd0} + {pc32[29:0], 2'b00};
        end else if (op == OPC_JAL) begin
            ex_wb_en = 1'b1;
            ex_wb    = {npc32[29:0], 2'b00};
            npc32    = pc32 + off_words(immj);
        end else if (op == OPC_JALR && f3 == F3_JALR) begin
            ex_wb_en = 1'b1;
            ex_wb    = {npc32[29:0], 2'b00};
            npc32    = {2'b00, sum_i[31:2]};
        end else if (op == OPC_BRANCH) begin
            logic t;
            t = 1'b0;
            case (f3)
                F3_BEQ:  t = (a == b);
                F3_BNE:  t = (a != b);
                F3_BLT:  t = ($signed(a) < $signed(b));
                F3_BGE:  t = !($signed(a) < $signed(b));
                F3_BLTU: t = (a < b);
                F3_BGEU: t = (a >= b);
                default: ex_ill = 1'b1;
            endcase
            if (t) begin
                npc32 = pc32 + off_words(immb);
            end
        end else if (op == OPC_LOAD) begin
            case (f3)
                F3_B, F3_H, F3_W, F3_BU, F3_HU: ex_load = 1'b1;
                default:                        ex_ill  = 1'b1;
            endcase
        end else if (op == OPC_STORE) begin
            case (f3)
                F3_B:    ex_st_val = {24'd0, b[7:0]};
                F3_H:    ex_st_val = {16'd0, b[15:0]};
                F3_W:    ex_st_val = b;
                default: ex_ill = 1'b1;
            endcase
            ex_st = !ex_ill && (st_idx < 30'(DMEM_WORDS));
        end else if (op == OPC_OPIMM) begin
            ex_wb_en = 1'b1;
            unique case (f3)
                F3_ADD:  ex_wb = sum_i;
                F3_SLL:  ex_wb = a << immi[4:0];
                F3_SLT:  ex_wb = {31'd0, $signed(a) < $signed(immi)};
                F3_SLTU: ex_wb = {31'd0, a < immi};
                F3_XOR:  ex_wb = a ^ immi;
                F3_SRL:  ex_wb = a >> immi[4:0];
                F3_OR:   ex_wb = a | immi;
                F3_AND:  ex_wb = a & immi;
            endcase
        end else if (op == OPC_OP) begin
            ex_wb_en = 1'b1;
            priority if (f3 == F3_ADD && f7 == F7_BASE)   ex_wb = a + b;
            else if (f3 == F3_ADD && f7 == F7_ALT)        ex_wb = a - b;
            else if (f3 == F3_ADD && f7 == F7_MULDIV)     ex_wb = a * b;
            else if (f3 == F3_DIV && f7 == F7_MULDIV) begin
                ex_wb_en = 1'b0;
                ex_div   = 1'b1;
            end
            else if (f3 == F3_SLL && f7 == F7_BASE)       ex_wb = a << b[4:0];
            else if (f3 == F3_SLTU && f7 == F7_BASE)      ex_wb = {31'd0, a < b};
            else if (f3 == F3_XOR && f7 == F7_BASE)       ex_wb = a ^ b;
            else if (f3 == F3_SRL && f7 == F7_BASE)       ex_wb = a >> b[4:0];
            else if (f3 == F3_OR)                         ex_wb = a | b;
            else if (f3 == F3_AND)                        ex_wb = a & b;
            else begin
                ex_wb_en = 1'b0;
                ex_ill   = 1'b1;
            end
        end else begin
            ex_ill = 1'b1;
        end
    end

    // load data alignment
    assign ld_m = r_ld_ok ? r_dm_q : 32'd0;
    always_comb begin
        case (f3)
            F3_B:    ld_val = {{24{ld_m[7]}}, ld_m[7:0]};
            F3_H:    ld_val = {{16{ld_m[15]}}, ld_m[15:0]};
            F3_BU:   ld_val = {24'd0, ld_m[7:0]};
            F3_HU:   ld_val = {16'd0, ld_m[15:0]};
            default: ld_val = ld_m;
        endcase
    end

    rv32ie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_EXEC) && ex_div),
        .i_dividend (a),
        .i_divisor  (b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_EXEC;
            S_EXEC: begin
                if (ex_div) begin
                    n_state = S_DIV;
                end else if (ex_load) begin
                    n_state = S_LOAD;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD:  if (out_free) n_state = S_IDLE;
            S_DIV:   if (div_done) n_state = S_DIVWB;
            S_DIVWB: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commit and write-back select
    always_comb begin
        commit = 1'b0;
        wb_val = ex_wb;
        wb_en  = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                commit = out_free && !ex_div && !ex_load;
                wb_en  = ex_wb_en;
            end
            S_LOAD: begin
                commit = out_free;
                wb_en  = 1'b1;
                wb_val = ld_val;
            end
            S_DIVWB: begin
                commit = out_free;
                wb_en  = 1'b1;
                wb_val = div_q;
            end
            default: commit = 1'b0;
        endcase
        // drop writes to x0
        wb_en = wb_en && commit && (rd != 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + DM_AW'(1);
            end
            if (commit) begin
                r_pc        <= PC_BITS'(npc32);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.next_pc   <= 16'(PC_BITS'(npc32));
            r_out.out_valid <= ex_ov;
            r_out.out_byte  <= ex_ob;
            r_out.in_used   <= ex_iu;
            r_out.illegal   <= ex_ill;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

@@ rtl/core/rv32ie_checker.sv @@
// Port-level checker for the integer execute block, bound into rv32im_integer_execute.
// Depends on rv32ie_pkg and rv32im_integer_execute_macros.svh.
`default_nettype none
`include "rv32im_integer_execute_macros.svh"
module rv32ie_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_stall,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_stall,
    input wire rv32ie_pkg::t_out_item i_out_data
);
    import rv32ie_pkg::*;

    `RV32IE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    `RV32IE_ASSERT_NOW(a_io_exclusive, i_clk, i_rst_n, i_out_valid, !(i_out_data.out_valid && i_out_data.in_used))
    `RV32IE_ASSERT_NOW(a_byte_only_on_out, i_clk, i_rst_n, i_out_valid && !i_out_data.out_valid, i_out_data.out_byte == 8'd0)
    `RV32IE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data))
endmodule

bind rv32im_integer_execute rv32ie_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for rv32im_integer_execute: predicts the register
// file, pc and data memory for every accepted instruction item and compares
// each output item. Depends on rv32ie_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
    import rv32ie_pkg::*;

    localparam int DMEM_WORDS = DMEM_WORDS_DEF;
    localparam int PC_BITS    = PC_BITS_DEF;
    localparam int N_RANDOM   = 930;
    localparam longint CYCLE_LIMIT = 64'd400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    rv32im_integer_execute i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Architectural state as predicted from the accepted instructions
    logic [31:0]        arch_regs [32];
    logic [PC_BITS-1:0] arch_pc;
    logic [31:0]        arch_mem [DMEM_WORDS];

    t_in_item  instr_queue [$];
    t_out_item expected_results [$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        recv_hold;
    longint    cycle_count;
    bit        stimulus_done;
    bit        in_taken;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] word_step(input logic [31:0] off);
        if (off[31]) return 32'd0 - ((32'd0 - off) >> 2);
        return off >> 2;
    endfunction

    function automatic logic signed_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [31:0] quotient_signed(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        if (b == 32'd0) return 32'hFFFF_FFFF;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h8000_0000;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] mem_load(input logic [31:0] addr);
        logic [31:0] idx;
        idx = addr >> 2;
        return (idx < DMEM_WORDS) ? arch_mem[idx] : 32'd0;
    endfunction

    task automatic reg_write(input logic [4:0] rd, input logic [31:0] v);
        if (rd != 5'd0) arch_regs[rd] = v;
    endtask

    task automatic mem_store(input logic [31:0] addr, input logic [31:0] v);
        logic [31:0] idx;
        idx = addr >> 2;
        if (idx < DMEM_WORDS) arch_mem[idx] = v;
    endtask

    // Execute one instruction on the predicted state and queue its result
    task automatic execute_instr(input t_in_item it);
        logic [31:0] w, a, b, immi, imms, immb, immj, npc, m, pc32;
        logic [6:0]  op, f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic        taken;
        t_out_item   r;
        w = it.instr_word;
        op = w[6:0];
        f3 = w[14:12];
        f7 = w[31:25];
        rd = w[11:7];
        a = arch_regs[w[19:15]];
        b = arch_regs[w[24:20]];
        immi = {{20{w[31]}}, w[31:20]};
        imms = {{20{w[31]}}, w[31:25], w[11:7]};
        immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        pc32 = 32'(arch_pc);
        npc = pc32 + 1;
        taken = 1'b0;
        r = '0;
        case (op)
            OPC_CUSTOM: begin
                if (!w[12]) begin
                    reg_write(rd, {arch_regs[rd][31:8], it.in_byte});
                    r.in_used = 1'b1;
                end else begin
                    r.out_valid = 1'b1;
                    r.out_byte = a[7:0];
                end
            end
            OPC_LUI:   reg_write(rd, {w[31:12], 12'd0});
            OPC_AUIPC: reg_write(rd, {w[31:12], 12'd0} + 4 * pc32);
            OPC_JAL: begin
                reg_write(rd, 4 * (pc32 + 1));
                npc = pc32 + word_step(immj);
            end
            OPC_JALR: begin
                if (f3 == F3_JALR) begin
                    reg_write(rd, 4 * (pc32 + 1));
                    npc = (a + immi) >> 2;
                end else r.illegal = 1'b1;
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  taken = (a == b);
                    F3_BNE:  taken = (a != b);
                    F3_BLT:  taken = signed_less(a, b);
                    F3_BGE:  taken = !signed_less(a, b);
                    F3_BLTU: taken = (a < b);
                    F3_BGEU: taken = (a >= b);
                    default: r.illegal = 1'b1;
                endcase
                if (taken) npc = pc32 + word_step(immb);
            end
            OPC_LOAD: begin
                m = mem_load(a + immi);
                case (f3)
                    F3_B:    reg_write(rd, {{24{m[7]}}, m[7:0]});
                    F3_H:    reg_write(rd, {{16{m[15]}}, m[15:0]});
                    F3_W:    reg_write(rd, m);
                    F3_BU:   reg_write(rd, {24'd0, m[7:0]});
                    F3_HU:   reg_write(rd, {16'd0, m[15:0]});
                    default: r.illegal = 1'b1;
                endcase
            end
            OPC_STORE: begin
                case (f3)
                    F3_B:    mem_store(a + imms, {24'd0, b[7:0]});
                    F3_H:    mem_store(a + imms, {16'd0, b[15:0]});
                    F3_W:    mem_store(a + imms, b);
                    default: r.illegal = 1'b1;
                endcase
            end
            OPC_OPIMM: begin
                case (f3)
                    F3_ADD:  reg_write(rd, a + immi);
                    F3_SLL:  reg_write(rd, a << immi[4:0]);
                    F3_SLT:  reg_write(rd, {31'd0, signed_less(a, immi)});
                    F3_SLTU: reg_write(rd, {31'd0, a < immi});
                    F3_XOR:  reg_write(rd, a ^ immi);
                    F3_SRL:  reg_write(rd, a >> immi[4:0]);
                    F3_OR:   reg_write(rd, a | immi);
                    default: reg_write(rd, a & immi);
                endcase
            end
            OPC_OP: begin
                if (f3 == F3_ADD && f7 == F7_BASE) reg_write(rd, a + b);
                else if (f3 == F3_ADD && f7 == F7_ALT) reg_write(rd, a - b);
                else if (f3 == F3_ADD && f7 == F7_MULDIV) reg_write(rd, a * b);
                else if (f3 == F3_DIV && f7 == F7_MULDIV) reg_write(rd, quotient_signed(a, b));
                else if (f3 == F3_SLL && f7 == F7_BASE) reg_write(rd, a << b[4:0]);
                else if (f3 == F3_SLTU && f7 == F7_BASE) reg_write(rd, {31'd0, a < b});
                else if (f3 == F3_XOR && f7 == F7_BASE) reg_write(rd, a ^ b);
                else if (f3 == F3_SRL && f7 == F7_BASE) reg_write(rd, a >> b[4:0]);
                else if (f3 == F3_OR) reg_write(rd, a | b);
                else if (f3 == F3_AND) reg_write(rd, a & b);
                else r.illegal = 1'b1;
            end
            default: r.illegal = 1'b1;
        endcase
        arch_pc = npc[PC_BITS-1:0];
        r.next_pc = 16'(arch_pc);
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    function automatic t_in_item make_item(input logic [31:0] w, input logic [7:0] ib);
        t_in_item it;
        it.instr_word = w;
        it.in_byte = ib;
        return it;
    endfunction

    function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
            input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
            input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
            input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] s_type(input logic [11:0] imm, input logic [4:0] rs2,
            input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] b_type(input logic [12:0] imm, input logic [4:0] rs2,
            input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    // Mostly well-formed instructions on few registers and low memory
    function automatic logic [31:0] random_instr();
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        int          k;
        rd  = 5'($urandom_range(0, 7));
        rs1 = 5'($urandom_range(0, 7));
        rs2 = 5'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) begin
            rd = 5'($urandom);
            rs1 = 5'($urandom);
            rs2 = 5'($urandom);
        end
        f3 = 3'($urandom);
        imm = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 64));
        k = $urandom_range(0, 99);
        if (k < 8) return {20'($urandom), rd, OPC_LUI};
        if (k < 12) return {20'($urandom), rd, OPC_AUIPC};
        if (k < 28) return i_type(imm, rs1, f3, rd, OPC_OPIMM);
        if (k < 44) begin
            logic [6:0] f7;
            case ($urandom_range(0, 4))
                0: f7 = F7_ALT;
                1, 2: f7 = F7_MULDIV;
                3: f7 = 7'($urandom);
                default: f7 = F7_BASE;
            endcase
            // keep divides rarer than other mul/div codes
            if (f7 == F7_MULDIV && f3 == F3_DIV && $urandom_range(0, 2) != 0) f3 = F3_ADD;
            return r_type(f7, rs2, rs1, f3, rd, OPC_OP);
        end
        if (k < 54) return i_type(imm, rs1, ($urandom_range(0, 7) == 0) ? f3 : F3_W
                                  ^ 3'($urandom_range(0, 1) * 2), rd, OPC_LOAD);
        if (k < 64) return s_type(imm, rs2, rs1, ($urandom_range(0, 7) == 0) ? f3 :
                                  3'($urandom_range(0, 2)));
        if (k < 72) return b_type(13'($urandom_range(0, 64)) - 13'd32, rs2, rs1, f3);
        if (k < 76) return {1'($urandom), 10'($urandom_range(0, 16)), 1'($urandom),
                            8'($urandom), rd, OPC_JAL};
        if (k < 80) return i_type(imm, rs1, ($urandom_range(0, 5) == 0) ? f3 : F3_JALR,
                                  rd, OPC_JALR);
        if (k < 92) return {17'($urandom), f3[0] ? 1'b1 : 1'b0, 14'($urandom)} & 32'hFFFF_FF80
                           | 32'(OPC_CUSTOM) | ({27'd0, rd} << 7);
        return $urandom;
    endfunction

    task automatic wait_drained();
        while (expected_results.size() != 0 || instr_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Driver: offer queued instruction items; hold an item until it is accepted
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // hold
        end else begin
            if (in_valid) void'(instr_queue.pop_front());
            if (instr_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data <= instr_queue[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            out_stall <= 1'b1;
            recv_hold <= recv_hold - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken <= i_rst_n && in_valid && !in_stall;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (in_valid && !in_stall) execute_instr(in_data);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", 32'(out_data.next_pc), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.next_pc !== want.next_pc)
                        report_mismatch("next_pc", 32'(out_data.next_pc), 32'(want.next_pc));
                    if (out_data.out_valid !== want.out_valid)
                        report_mismatch("out_valid", 32'(out_data.out_valid),
                                        32'(want.out_valid));
                    if (out_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
                    if (out_data.in_used !== want.in_used)
                        report_mismatch("in_used", 32'(out_data.in_used), 32'(want.in_used));
                    if (out_data.illegal !== want.illegal)
                        report_mismatch("illegal", 32'(out_data.illegal), 32'(want.illegal));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        recv_hold = 0;
        cycle_count = 0;
        error_count = 0;
        stimulus_done = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 45;
        arch_pc = '0;
        foreach (arch_regs[i]) arch_regs[i] = 32'd0;
        foreach (arch_mem[i]) arch_mem[i] = 32'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every opcode, divide corner cases, x0 writes
        instr_queue.push_back(make_item(32'h0000_000B | (5'd1 << 7), 8'hFF));
        instr_queue.push_back(make_item({20'h80000, 5'd2, OPC_LUI}, 8'h00));
        instr_queue.push_back(make_item(i_type(12'hFFF, 5'd0, F3_ADD, 5'd3, OPC_OPIMM), 8'h0));
        instr_queue.push_back(make_item(r_type(F7_MULDIV, 5'd3, 5'd2, F3_DIV, 5'd4, OPC_OP),
                                        8'h00));
        instr_queue.push_back(make_item(r_type(F7_MULDIV, 5'd0, 5'd2, F3_DIV, 5'd5, OPC_OP),
                                        8'h00));
        instr_queue.push_back(make_item(r_type(F7_MULDIV, 5'd3, 5'd3, F3_ADD, 5'd6, OPC_OP),
                                        8'h00));
        instr_queue.push_back(make_item(r_type(F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd0, OPC_OP), 8'h00));
        instr_queue.push_back(make_item(r_type(F7_ALT, 5'd1, 5'd2, F3_SRL, 5'd7, OPC_OP), 8'h00));
        instr_queue.push_back(make_item(i_type(12'h43F, 5'd2, F3_SRL, 5'd7, OPC_OPIMM), 8'h00));
        instr_queue.push_back(make_item(r_type(F7_BASE, 5'd3, 5'd1, F3_SLL, 5'd8, OPC_OP), 8'h00));
        instr_queue.push_back(make_item(s_type(12'h7FC, 5'd2, 5'd0, F3_W), 8'h00));
        instr_queue.push_back(make_item(s_type(12'h800, 5'd2, 5'd0, F3_B), 8'h00));
        instr_queue.push_back(make_item(i_type(12'h7FC, 5'd0, F3_B, 5'd9, OPC_LOAD), 8'h00));
        instr_queue.push_back(make_item(i_type(12'h7FC, 5'd0, F3_HU, 5'd9, OPC_LOAD), 8'h00));
        instr_queue.push_back(make_item(i_type(12'h7FC, 5'd0, 3'd3, 5'd9, OPC_LOAD), 8'h00));
        instr_queue.push_back(make_item(b_type(13'h1FF8, 5'd3, 5'd2, F3_BGE), 8'h00));
        instr_queue.push_back(make_item(b_type(13'h0010, 5'd3, 5'd2, F3_BLTU), 8'h00));
        instr_queue.push_back(make_item(b_type(13'h0008, 5'd0, 5'd0, 3'd2), 8'h00));
        instr_queue.push_back(make_item({20'hFFFFF, 5'd10, OPC_AUIPC}, 8'h00));
        instr_queue.push_back(make_item({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd11, OPC_JAL}, 8'h00));
        instr_queue.push_back(make_item(i_type(12'h008, 5'd0, F3_JALR, 5'd12, OPC_JALR), 8'h00));
        instr_queue.push_back(make_item(i_type(12'h008, 5'd0, 3'd1, 5'd12, OPC_JALR), 8'h00));
        instr_queue.push_back(make_item(32'h0000_100B | (5'd2 << 15), 8'h5A));
        instr_queue.push_back(make_item(32'hFFFF_FFFF, 8'hFF));
        instr_queue.push_back(make_item(32'h0000_0053, 8'h00));
        wait_drained();

        // Random phases with changing idle profiles; long receiver hold-off first
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 20 : 0;
            if (phase == 0) recv_hold <= 300;
            n = N_RANDOM / 3;
            for (int i = 0; i < n; i++) begin
                instr_queue.push_back(make_item(random_instr(), 8'($urandom)));
                if (instr_queue.size() > 16) begin
                    while (instr_queue.size() > 4) @(posedge i_clk);
                end
            end
            // pause the sender until every result has arrived
            wait_drained();
        end
        stimulus_done = 1'b1;
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
